### hw/rtl/amdfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package amdfs_pkg;

	localparam int MAX_CITIES = 16;
	localparam int CITY_W     = $clog2(MAX_CITIES);
	localparam int CNT_W      = $clog2(MAX_CITIES + 1);
	localparam int DIST_W     = 16;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_START = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_SCAN,
		ST_EMIT
	} walk_state_t;

	typedef struct packed {
		logic              en;
		logic [CITY_W-1:0] row;
		logic [CITY_W-1:0] col;
		logic              set;
	} edge_wr_t;

endpackage
`default_nettype wire

### hw/rtl/amdfs_edge_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module amdfs_edge_mem
	import amdfs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire edge_wr_t              wr,
	input  wire logic [CITY_W-1:0]     rd_row,
	output logic      [MAX_CITIES-1:0] rd_bits
);

	logic [MAX_CITIES-1:0] rows_q [MAX_CITIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CITIES; i++) begin
				rows_q[i] <= '0;
			end
		end else if (wr.en) begin
			rows_q[wr.row][wr.col] <= wr.set;
		end
	end

	assign rd_bits = rows_q[rd_row];

endmodule
`default_nettype wire

### hw/rtl/amdfs_walk.sv
`timescale 1ns / 1ps
`default_nettype none
module amdfs_walk
	import amdfs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  go,
	input  wire logic [CITY_W-1:0]     start_city,
	input  wire logic [CNT_W-1:0]      count,
	input  wire logic [MAX_CITIES-1:0] row_bits,
	output logic      [CITY_W-1:0]     rd_row,
	output logic                       busy,
	output logic                       strobe,
	output logic      [CITY_W-1:0]     city_index,
	output logic      [CNT_W-1:0]      visit_order,
	output logic                       last_city
);

	walk_state_t state_q, state_d;

	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      n_eff;
	logic [CNT_W-1:0]      nm1;
	logic [CNT_W-1:0]      depth_q;
	logic [CNT_W-1:0]      depth_m1;
	logic [CNT_W-1:0]      counter_q;
	logic [MAX_CITIES-1:0] seen_q;
	logic [CNT_W-1:0]      visit_q [MAX_CITIES];
	logic [CITY_W-1:0]     stack_q [MAX_CITIES];
	logic [CITY_W-1:0]     cur_q;
	logic [CITY_W-1:0]     j_q;
	logic [CITY_W-1:0]     idx_q;
	logic                  start_ok;
	logic                  hit;
	logic                  emit_last;

	assign n_eff     = (count > CNT_W'(MAX_CITIES)) ? CNT_W'(MAX_CITIES) : count;
	assign start_ok  = {1'b0, start_city} < n_eff;
	assign nm1       = n_q - CNT_W'(1);
	assign depth_m1  = depth_q - CNT_W'(1);
	assign hit       = row_bits[j_q] && !seen_q[j_q];
	assign emit_last = {1'b0, idx_q} == nm1;
	assign rd_row    = cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		busy        = 1'b1;
		strobe      = 1'b0;
		city_index  = '0;
		visit_order = '0;
		last_city   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (go && n_eff != '0) begin
					state_d = start_ok ? ST_POP : ST_EMIT;
				end
			end
			ST_POP: begin
				state_d = (depth_q == '0) ? ST_EMIT : ST_SCAN;
			end
			ST_SCAN: begin
				if (j_q == '0) begin
					state_d = ST_POP;
				end
			end
			ST_EMIT: begin
				strobe      = 1'b1;
				city_index  = idx_q;
				visit_order = visit_q[idx_q];
				last_city   = emit_last;
				if (emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			depth_q   <= '0;
			counter_q <= '0;
			seen_q    <= '0;
			cur_q     <= '0;
			j_q       <= '0;
			idx_q     <= '0;
			for (int i = 0; i < MAX_CITIES; i++) begin
				visit_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (go && n_eff != '0) begin
						n_q       <= n_eff;
						counter_q <= '0;
						for (int i = 0; i < MAX_CITIES; i++) begin
							visit_q[i] <= '0;
						end
						if (start_ok) begin
							depth_q <= CNT_W'(1);
							seen_q  <= MAX_CITIES'(1) << start_city;
						end else begin
							depth_q <= '0;
							seen_q  <= '0;
						end
					end
				end
				ST_POP: begin
					if (depth_q != '0) begin
						depth_q                    <= depth_m1;
						cur_q                      <= stack_q[depth_m1[CITY_W-1:0]];
						counter_q                  <= counter_q + CNT_W'(1);
						visit_q[stack_q[depth_m1[CITY_W-1:0]]] <= counter_q + CNT_W'(1);
						j_q                        <= nm1[CITY_W-1:0];
					end
				end
				ST_SCAN: begin
					if (hit) begin
						depth_q     <= depth_q + CNT_W'(1);
						seen_q[j_q] <= 1'b1;
					end
					j_q <= j_q - CITY_W'(1);
				end
				ST_EMIT: begin
					idx_q <= idx_q + CITY_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && go && start_ok) begin
			stack_q[0] <= start_city;
		end else if (state_q == ST_SCAN && hit) begin
			stack_q[depth_q[CITY_W-1:0]] <= j_q;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/adjacency_matrix_dfs_order_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Depth-first visit order over an adjacency matrix of up to 16 cities. A transfer with
// opcode OP_WRITE sets or clears one edge. A transfer with opcode OP_START runs a stack
// walk from start_city over the first city_count cities, then reports one result per
// city on consecutive cycles, marked by strobe, with last_city on the final one. The
// receiver cannot stall: each result is shown for exactly one cycle. The row scan tests
// one matrix entry per cycle. busy stays high until the last result has been shown.
module adjacency_matrix_dfs_order_core
	import amdfs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              opcode,
	input  wire logic [CITY_W-1:0] row_city,
	input  wire logic [CITY_W-1:0] col_city,
	input  wire logic [DIST_W-1:0] distance,
	input  wire logic [CITY_W-1:0] start_city,
	input  wire logic              city_count_we,
	input  wire logic [CNT_W-1:0]  city_count,
	output logic                   strobe,
	output logic      [CITY_W-1:0] city_index,
	output logic      [CNT_W-1:0]  visit_order,
	output logic                   last_city
);

	logic [CNT_W-1:0]      count_q;
	logic                  accept;
	edge_wr_t              wr;
	logic [CITY_W-1:0]     rd_row;
	logic [MAX_CITIES-1:0] row_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(MAX_CITIES);
		end else if (city_count_we) begin
			count_q <= city_count;
		end
	end

	assign accept = start && !busy;
	assign wr.en  = accept && (opcode == OP_WRITE);
	assign wr.row = row_city;
	assign wr.col = col_city;
	assign wr.set = distance != '0;

	amdfs_edge_mem u_edge_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_row  (rd_row),
		.rd_bits (row_bits)
	);

	amdfs_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (accept && (opcode == OP_START)),
		.start_city  (start_city),
		.count       (count_q),
		.row_bits    (row_bits),
		.rd_row      (rd_row),
		.busy        (busy),
		.strobe      (strobe),
		.city_index  (city_index),
		.visit_order (visit_order),
		.last_city   (last_city)
	);

`ifndef SYNTHESIS
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result shown while idle");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_city |=> !busy && !strobe)
		else $error("results continue after last city");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_city |=> strobe && (city_index == $past(city_index) + 4'd1))
		else $error("result index did not advance");

	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (opcode == OP_WRITE) |=> !busy)
		else $error("matrix write raised busy");
`endif

endmodule
`default_nettype wire
